@@ hw/rtl/slpe_pkg.sv @@
// Shared types and constants for the status LED pattern engine.
// Holds the mode codes, the register indexes, the register reset values and the
// configuration struct. Depends on nothing.
package slpe_pkg;

   localparam int TIME_BITS_DEFAULT = 32;

   localparam int MODE_BITS      = 3;
   localparam int LEVEL_BITS     = 8;
   localparam int PERIOD_BITS    = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_OFF    = 3'd0,
      MODE_PULSE  = 3'd1,
      MODE_SOLID  = 3'd2,
      MODE_SLOW   = 3'd3,
      MODE_FAST   = 3'd4,
      MODE_DOUBLE = 3'd5,
      MODE_TRIPLE = 3'd6
   } mode_type;

   // Code seven has no meaning; it is filtered to off before use.
   localparam logic [MODE_BITS-1:0] MODE_INVALID = 3'd7;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PULSE_INTERVAL = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FADE_STEP      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SLOW_BLINK     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FAST_BLINK     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOLID_LEVEL    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_TOGGLE = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_PAUSE  = 3'd6;

   localparam logic [PERIOD_BITS-1:0] PULSE_INTERVAL_RESET = 16'd10;
   localparam logic [LEVEL_BITS-1:0]  FADE_STEP_RESET      = 8'd5;
   localparam logic [PERIOD_BITS-1:0] SLOW_BLINK_RESET     = 16'd500;
   localparam logic [PERIOD_BITS-1:0] FAST_BLINK_RESET     = 16'd120;
   localparam logic [LEVEL_BITS-1:0]  SOLID_LEVEL_RESET    = 8'd100;
   localparam logic [PERIOD_BITS-1:0] PATTERN_TOGGLE_RESET = 16'd200;
   localparam logic [PERIOD_BITS-1:0] PATTERN_PAUSE_RESET  = 16'd1000;

   localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = 8'd255;

   typedef struct packed {
      logic [PERIOD_BITS-1:0] pulse_interval_ms;
      logic [LEVEL_BITS-1:0]  fade_step;
      logic [PERIOD_BITS-1:0] slow_blink_ms;
      logic [PERIOD_BITS-1:0] fast_blink_ms;
      logic [LEVEL_BITS-1:0]  solid_level;
      logic [PERIOD_BITS-1:0] pattern_toggle_ms;
      logic [PERIOD_BITS-1:0] pattern_pause_ms;
   } cfg_type;

endpackage

@@ hw/rtl/slpe_config_regs.sv @@
// Configuration register file of the status LED pattern engine.
// Decodes the plain write port into the register struct; depends on slpe_pkg.
module slpe_config_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [slpe_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [slpe_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output slpe_pkg::cfg_type                    cfg
);
   import slpe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_PULSE_INTERVAL: cfg_in.pulse_interval_ms = csr_wdata;
            REG_FADE_STEP:      cfg_in.fade_step         = csr_wdata[LEVEL_BITS-1:0];
            REG_SLOW_BLINK:     cfg_in.slow_blink_ms     = csr_wdata;
            REG_FAST_BLINK:     cfg_in.fast_blink_ms     = csr_wdata;
            REG_SOLID_LEVEL:    cfg_in.solid_level       = csr_wdata[LEVEL_BITS-1:0];
            REG_PATTERN_TOGGLE: cfg_in.pattern_toggle_ms = csr_wdata;
            REG_PATTERN_PAUSE:  cfg_in.pattern_pause_ms  = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_interval_ms <= PULSE_INTERVAL_RESET;
         cfg_ff.fade_step         <= FADE_STEP_RESET;
         cfg_ff.slow_blink_ms     <= SLOW_BLINK_RESET;
         cfg_ff.fast_blink_ms     <= FAST_BLINK_RESET;
         cfg_ff.solid_level       <= SOLID_LEVEL_RESET;
         cfg_ff.pattern_toggle_ms <= PATTERN_TOGGLE_RESET;
         cfg_ff.pattern_pause_ms  <= PATTERN_PAUSE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/slpe_pattern_core.sv @@
// Tick processing core of the status LED pattern engine: mode selection,
// millisecond counter, fade, blink and pattern state. Depends on slpe_pkg.
module slpe_pattern_core #(
   parameter int TIME_BITS = slpe_pkg::TIME_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step_en,
   input  logic [slpe_pkg::MODE_BITS-1:0]   base_mode,
   input  logic [slpe_pkg::MODE_BITS-1:0]   override_mode,
   input  slpe_pkg::cfg_type                cfg,
   output logic [slpe_pkg::LEVEL_BITS-1:0]  led_level,
   output logic [slpe_pkg::MODE_BITS-1:0]   active_mode
);
   import slpe_pkg::*;

   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic [TIME_BITS-1:0]  last_step_ff, last_step_in;
   logic [TIME_BITS-1:0]  pattern_last_ff, pattern_last_in;
   logic [TIME_BITS-1:0]  pause_begin_ff, pause_begin_in;
   logic [LEVEL_BITS-1:0] fade_level_ff, fade_level_in;
   logic                  fade_rising_ff, fade_rising_in;
   logic                  blink_on_ff, blink_on_in;
   logic [1:0]            blinks_ff, blinks_in;
   logic                  pausing_ff, pausing_in;
   logic                  pattern_on_ff, pattern_on_in;
   logic [LEVEL_BITS-1:0] drive_ff, drive_in;

   logic [MODE_BITS-1:0]  base_clean;
   logic [MODE_BITS-1:0]  over_clean;
   logic [MODE_BITS-1:0]  mode_sel;
   logic [TIME_BITS-1:0]  now;
   logic                  pulse_due, slow_due, fast_due, toggle_due, pause_done;
   logic signed [9:0]     fade_sum;
   logic [1:0]            blinks_inc;
   logic [1:0]            group_size;

   assign base_clean = (base_mode == MODE_INVALID) ? MODE_OFF : base_mode;
   assign over_clean = (override_mode == MODE_INVALID) ? MODE_OFF : override_mode;
   assign mode_sel   = (over_clean != MODE_OFF) ? over_clean : base_clean;

   assign now = time_ff + TIME_BITS'(1);

   // Elapsed times wrap at the counter width.
   assign pulse_due  = (now - last_step_ff)    >= TIME_BITS'(cfg.pulse_interval_ms);
   assign slow_due   = (now - last_step_ff)    >= TIME_BITS'(cfg.slow_blink_ms);
   assign fast_due   = (now - last_step_ff)    >= TIME_BITS'(cfg.fast_blink_ms);
   assign toggle_due = (now - pattern_last_ff) >= TIME_BITS'(cfg.pattern_toggle_ms);
   assign pause_done = (now - pause_begin_ff)  >= TIME_BITS'(cfg.pattern_pause_ms);

   assign fade_sum = fade_rising_ff
                   ? $signed({2'b00, fade_level_ff}) + $signed({2'b00, cfg.fade_step})
                   : $signed({2'b00, fade_level_ff}) - $signed({2'b00, cfg.fade_step});

   assign blinks_inc = blinks_ff + 2'd1;
   assign group_size = (mode_sel == MODE_TRIPLE) ? 2'd3 : 2'd2;

   always_comb begin
      time_in         = now;
      last_step_in    = last_step_ff;
      pattern_last_in = pattern_last_ff;
      pause_begin_in  = pause_begin_ff;
      fade_level_in   = fade_level_ff;
      fade_rising_in  = fade_rising_ff;
      blink_on_in     = blink_on_ff;
      blinks_in       = blinks_ff;
      pausing_in      = pausing_ff;
      pattern_on_in   = pattern_on_ff;
      drive_in        = drive_ff;

      unique case (mode_type'(mode_sel))
         MODE_PULSE: begin
            if (pulse_due) begin
               last_step_in = now;
               if (fade_sum <= 10'sd0 || fade_sum >= 10'sd255) begin
                  fade_rising_in = !fade_rising_ff;
               end
               if (fade_sum < 10'sd0) begin
                  fade_level_in = '0;
               end else if (fade_sum > 10'sd255) begin
                  fade_level_in = LEVEL_FULL;
               end else begin
                  fade_level_in = fade_sum[LEVEL_BITS-1:0];
               end
               drive_in = fade_level_in;
            end
         end
         MODE_SOLID: drive_in = cfg.solid_level;
         MODE_SLOW, MODE_FAST: begin
            if ((mode_sel == MODE_SLOW) ? slow_due : fast_due) begin
               last_step_in = now;
               blink_on_in  = !blink_on_ff;
               drive_in     = blink_on_ff ? '0 : LEVEL_FULL;
            end
         end
         MODE_DOUBLE, MODE_TRIPLE: begin
            if (!pausing_ff && toggle_due) begin
               pattern_last_in = now;
               pattern_on_in   = !pattern_on_ff;
               if (!pattern_on_ff) begin
                  drive_in = cfg.solid_level;
               end else begin
                  drive_in = '0;
                  if (blinks_inc >= group_size) begin
                     blinks_in      = 2'd0;
                     pausing_in     = 1'b1;
                     pause_begin_in = now;
                  end else begin
                     blinks_in = blinks_inc;
                  end
               end
            end else if (pausing_ff && pause_done) begin
               pausing_in = 1'b0;
            end
         end
         default: drive_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff         <= '0;
         last_step_ff    <= '0;
         pattern_last_ff <= '0;
         pause_begin_ff  <= '0;
         fade_level_ff   <= '0;
         fade_rising_ff  <= 1'b1;
         blink_on_ff     <= 1'b0;
         blinks_ff       <= 2'd0;
         pausing_ff      <= 1'b0;
         pattern_on_ff   <= 1'b0;
         drive_ff        <= '0;
      end else if (step_en) begin
         time_ff         <= time_in;
         last_step_ff    <= last_step_in;
         pattern_last_ff <= pattern_last_in;
         pause_begin_ff  <= pause_begin_in;
         fade_level_ff   <= fade_level_in;
         fade_rising_ff  <= fade_rising_in;
         blink_on_ff     <= blink_on_in;
         blinks_ff       <= blinks_in;
         pausing_ff      <= pausing_in;
         pattern_on_ff   <= pattern_on_in;
         drive_ff        <= drive_in;
      end
   end

   assign led_level   = drive_in;
   assign active_mode = mode_sel;

endmodule

@@ hw/rtl/status_led_pattern_engine_unit.sv @@
// Top level of the status LED pattern engine.
// Instantiates slpe_config_regs and slpe_pattern_core; depends on slpe_pkg.
//
// Each input transaction is one millisecond tick carrying a base LED mode and
// an override mode (0 off, 1 pulse, 2 solid, 3 slow blink, 4 fast blink,
// 5 double blink, 6 triple blink; code seven counts as off). For every tick
// the block returns exactly one result transaction with the LED drive level
// and the mode that was chosen. The block takes one transaction per clock
// cycle unless a stalled result holds it back. A tick waits in the input
// register while the single update pass of the pattern core works on it. Its
// result is loaded into the result register, from which it shows on the
// result port. A stalled result holds the tick behind it in the input register.
// Ticks may arrive back to back and may stall freely on either side.
// Configuration registers must be written through the csr_ port only while
// no tick is in flight; the block does not enforce this. A write to an index
// beyond the seven registers is ignored.
module status_led_pattern_engine_unit #(
   parameter int TIME_BITS = slpe_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Tick input channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // base_mode[2:0], override_mode[5:3]
   // Result channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [15:0]                          rsp_tdata,  // led_level[7:0], active_mode[10:8]
   // Configuration write port.
   input  logic                                 csr_wr_en,
   input  logic [slpe_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [slpe_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import slpe_pkg::*;

   cfg_type               cfg;

   // Input register.
   logic                  in_valid_ff;
   logic [MODE_BITS-1:0]  in_base_ff;
   logic [MODE_BITS-1:0]  in_over_ff;

   // Result register.
   logic                  out_valid_ff;
   logic [LEVEL_BITS-1:0] out_level_ff;
   logic [MODE_BITS-1:0]  out_mode_ff;

   logic                  advance;
   logic                  req_take;
   logic [LEVEL_BITS-1:0] core_level;
   logic [MODE_BITS-1:0]  core_mode;

   // The held tick moves into the result register whenever that register is
   // empty or its transaction is being taken in the same cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   slpe_config_regs u_config (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slpe_pattern_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .base_mode     (in_base_ff),
      .override_mode (in_over_ff),
      .cfg           (cfg),
      .led_level     (core_level),
      .active_mode   (core_mode)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_base_ff <= req_tdata[2:0];
         in_over_ff <= req_tdata[5:3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_level_ff <= core_level;
         out_mode_ff  <= core_mode;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_mode_ff, out_level_ff};

endmodule

@@ hw/rtl/slpe_checker.sv @@
// Port-level checker for the status LED pattern engine, bound to the top level.
// Watches only the top level's ports; depends on nothing else.
module slpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled result transaction keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result transaction changed while stalled");

   // The meaningless mode code is never reported as the chosen mode.
   a_mode_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:8] != 3'd7)
      else $error("result reports mode code seven");

   // A tick that resolves to off always drives the LED dark.
   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10:8] == 3'd0 |-> rsp_tdata[7:0] == 8'd0)
      else $error("off mode with nonzero level");

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind status_led_pattern_engine_unit slpe_checker u_slpe_checker (.*);
